FILE: rtl/fxaa_pkg.sv
// Shared types, register map, defaults and the luma function of the frame filter.
`default_nettype none

package fxaa_pkg;

  localparam int DEF_MAX_WIDTH  = 512;
  localparam int DEF_MAX_HEIGHT = 512;
  localparam int DEF_MAX_SEARCH = 32;

  localparam int APB_AW = 5;

  // 2^23 / 9 rounded up: floor(s * RECIP9 >> 23) == s / 9 for s below 2^21
  localparam logic [19:0] RECIP9 = 20'd932068;

  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_FILTER = 2'd1,
    CMD_READ   = 2'd2,
    CMD_NONE   = 2'd3
  } command_t;

  typedef enum logic [2:0] {
    REG_FRAME_WIDTH   = 3'd0,
    REG_FRAME_HEIGHT  = 3'd1,
    REG_EDGE_FLOOR    = 3'd2,
    REG_EDGE_RATIO    = 3'd3,
    REG_SUBPIXEL_TRIM = 3'd4,
    REG_SUBPIXEL_CAP  = 3'd5,
    REG_SEARCH_STEPS  = 3'd6,
    REG_UNUSED        = 3'd7
  } reg_index_t;

  localparam logic [9:0]  RST_FRAME_WIDTH   = 10'd512;
  localparam logic [9:0]  RST_FRAME_HEIGHT  = 10'd512;
  localparam logic [15:0] RST_EDGE_FLOOR    = 16'd16;
  localparam logic [7:0]  RST_EDGE_RATIO    = 8'd32;
  localparam logic [7:0]  RST_SUBPIXEL_TRIM = 8'd64;
  localparam logic [7:0]  RST_SUBPIXEL_CAP  = 8'd192;
  localparam logic [5:0]  RST_SEARCH_STEPS  = 6'd8;

  typedef struct packed {
    logic [1:0]  command;
    logic [8:0]  column;
    logic [8:0]  row;
    logic [15:0] red_in;
    logic [15:0] green_in;
    logic [15:0] blue_in;
  } req_t;

  typedef struct packed {
    logic [15:0] red_out;
    logic [15:0] green_out;
    logic [15:0] blue_out;
    logic        filter_done;
  } rsp_t;

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
  } pixel_t;

  // Q16.8 luma, 77/150/29 weights; the maximum fits in 24 bits
  function automatic logic [23:0] luma(input pixel_t p);
    logic [23:0] lr, lg, lb;
    lr = {8'd0, p.red}   * 24'd77;
    lg = {8'd0, p.green} * 24'd150;
    lb = {8'd0, p.blue}  * 24'd29;
    return lr + lg + lb;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/fxaa_frame_filter_top.sv
// Frame buffer with an in-place FXAA filter, APB register port and one frame memory.
// Frame store of MAX_WIDTH*MAX_HEIGHT 48-bit RGB pixels in one synchronous memory,
// addressed row*MAX_WIDTH+column; its contents are undefined until written and there
// is no clearing pass. A write request returns nothing; a read request returns the
// pixel, or zeros outside the store. A filter request walks the interior in raster
// order, updating in place, and returns filter_done when finished. Every read goes
// through the single read port and division goes through one bit-serial divider: a
// pixel below the edge threshold is skipped without a write, an edge pixel is searched
// along its edge and written back. Registers live at byte address 4*index; frame size
// saturates at the store size.
`default_nettype none

module fxaa_frame_filter_top
  import fxaa_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int MAX_SEARCH = DEF_MAX_SEARCH
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_ready,
  input  wire req_t              req,
  output logic                   rsp_valid,
  input  wire logic              rsp_ready,
  output rsp_t                   rsp,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int XW    = $clog2(MAX_WIDTH + 1);
  localparam int YW    = $clog2(MAX_HEIGHT + 1);
  localparam int SW    = $clog2(MAX_SEARCH + 1);

  typedef enum logic [20:0] {
    S_IDLE   = 21'h000001,
    S_RD     = 21'h000002,
    S_DONE   = 21'h000004,
    S_LOAD   = 21'h000008,
    S_RANGE  = 21'h000010,
    S_THR    = 21'h000020,
    S_DIV    = 21'h000040,
    S_BLEND1 = 21'h000080,
    S_BLEND2 = 21'h000100,
    S_SSET   = 21'h000200,
    S_SRCH   = 21'h000400,
    S_SWAIT  = 21'h000800,
    S_SCMP   = 21'h001000,
    S_FBSET  = 21'h002000,
    S_FBB    = 21'h004000,
    S_MEAN   = 21'h008000,
    S_CONTR  = 21'h010000,
    S_CF     = 21'h020000,
    S_MIX    = 21'h040000,
    S_WB     = 21'h080000,
    S_NEXT   = 21'h100000
  } state_t;

  state_t state;

  // configuration
  logic [9:0]  frame_width, frame_height;
  logic [15:0] edge_floor;
  logic [7:0]  edge_ratio, subpixel_trim, subpixel_cap;
  logic [5:0]  search_steps;

  // frame memory
  pixel_t          mem [DEPTH];
  pixel_t          rdata;
  logic            mem_we, mem_re;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  pixel_t          mem_wdata;

  // walk and window
  logic [XW-1:0] wlim, x, sx;
  logic [YW-1:0] hlim, y, sy;
  logic [3:0]    lidx;
  logic [1:0]    wi, wj;
  logic [23:0]   lm [9];
  logic [19:0]   sums [3];
  logic [15:0]   mch [3];
  logic [15:0]   newc [3];
  logic [15:0]   mean [3];
  logic          rd_inside;

  // per-pixel arithmetic
  logic [23:0] hi, lo, rng, diffl, slum;
  logic [27:0] ev, eh, grad4;
  logic        horz, dir, div_fb;
  logic [24:0] dr;
  logic [23:0] dden;
  logic [16:0] q;
  logic [4:0]  dcnt;
  logic [24:0] bt;
  logic [15:0] blendl;
  logic [16:0] fbb, blend;
  logic [17:0] contrast;
  logic [32:0] acc;
  logic [1:0]  ch;
  logic        phase;
  logic [SW-1:0] tries, dist_n, dist_p, stepsmax;

  // combinational helpers
  logic          cfg_we;
  logic [2:0]    cfg_idx;
  logic          req_inside, take;
  logic [XW-1:0] wsat;
  logic [YW-1:0] hsat;
  logic [XW-1:0] nx;
  logic [YW-1:0] ny;
  logic          dir_end;
  logic [24:0]   rs;
  logic          rs_ge;
  logic [23:0]   t_hi, t_lo, t_thr, ratio_thr, s_diff;
  logic [25:0]   lsum;
  logic [23:0]   lumal;
  logic [31:0]   hprod;
  logic [16:0]   rdiff;
  logic [26:0]   bt3;
  logic [32:0]   fprod;
  logic [39:0]   mprod;
  logic [25:0]   cprod;
  logic [16:0]   cf;
  logic [32:0]   mix_sum;
  logic          hit;

  function automatic logic [23:0] absdiff(input logic [23:0] a, input logic [23:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

  // |a + c - 2b|
  function automatic logic [25:0] lap(input logic [23:0] a, input logic [23:0] b,
                                      input logic [23:0] c);
    logic [25:0] s1, s2;
    s1 = 26'(a) + 26'(c);
    s2 = {1'b0, b, 1'b0};
    return (s1 >= s2) ? s1 - s2 : s2 - s1;
  endfunction

  function automatic logic [AW-1:0] addr_of(input logic [AW-1:0] xx, input logic [AW-1:0] yy);
    return yy * AW'(MAX_WIDTH) + xx;
  endfunction

  function automatic logic [23:0] max24(input logic [23:0] a, input logic [23:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic [23:0] min24(input logic [23:0] a, input logic [23:0] b);
    return (a < b) ? a : b;
  endfunction

  // ---------------------------------------------------------------- APB
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = paddr[4:2];

  always_comb begin
    unique case (reg_index_t'(cfg_idx))
      REG_FRAME_WIDTH:   prdata = 32'(frame_width);
      REG_FRAME_HEIGHT:  prdata = 32'(frame_height);
      REG_EDGE_FLOOR:    prdata = 32'(edge_floor);
      REG_EDGE_RATIO:    prdata = 32'(edge_ratio);
      REG_SUBPIXEL_TRIM: prdata = 32'(subpixel_trim);
      REG_SUBPIXEL_CAP:  prdata = 32'(subpixel_cap);
      REG_SEARCH_STEPS:  prdata = 32'(search_steps);
      default:           prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width   <= RST_FRAME_WIDTH;
      frame_height  <= RST_FRAME_HEIGHT;
      edge_floor    <= RST_EDGE_FLOOR;
      edge_ratio    <= RST_EDGE_RATIO;
      subpixel_trim <= RST_SUBPIXEL_TRIM;
      subpixel_cap  <= RST_SUBPIXEL_CAP;
      search_steps  <= RST_SEARCH_STEPS;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_idx))
        REG_FRAME_WIDTH:   frame_width   <= pwdata[9:0];
        REG_FRAME_HEIGHT:  frame_height  <= pwdata[9:0];
        REG_EDGE_FLOOR:    edge_floor    <= pwdata[15:0];
        REG_EDGE_RATIO:    edge_ratio    <= pwdata[7:0];
        REG_SUBPIXEL_TRIM: subpixel_trim <= pwdata[7:0];
        REG_SUBPIXEL_CAP:  subpixel_cap  <= pwdata[7:0];
        REG_SEARCH_STEPS:  search_steps  <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- combinational
  assign req_ready  = (state == S_IDLE);
  assign take       = req_valid && req_ready;
  assign req_inside = (32'(req.column) < MAX_WIDTH) && (32'(req.row) < MAX_HEIGHT);
  assign wsat = (32'(frame_width) < MAX_WIDTH)   ? XW'(frame_width)  : XW'(MAX_WIDTH);
  assign hsat = (32'(frame_height) < MAX_HEIGHT) ? YW'(frame_height) : YW'(MAX_HEIGHT);
  assign stepsmax = (32'(search_steps) < MAX_SEARCH) ? SW'(search_steps) : SW'(MAX_SEARCH);

  // next search sample and end of the search (frame edge or step limit) along the search axis
  always_comb begin
    nx = sx;
    ny = sy;
    dir_end = 1'b0;
    if (horz) begin
      nx = dir ? sx + XW'(1) : sx - XW'(1);
      dir_end = dir ? ((XW'(sx) + XW'(1)) >= wlim) : (sx == '0);
    end else begin
      ny = dir ? sy + YW'(1) : sy - YW'(1);
      dir_end = dir ? ((YW'(sy) + YW'(1)) >= hlim) : (sy == '0);
    end
    if (tries == stepsmax) dir_end = 1'b1;
  end

  always_comb begin
    t_hi  = max24(lm[4], max24(max24(lm[1], lm[3]), max24(lm[7], lm[5])));
    t_lo  = min24(lm[4], min24(min24(lm[1], lm[3]), min24(lm[7], lm[5])));
    lsum  = 26'(lm[1]) + 26'(lm[3]) + 26'(lm[5]) + 26'(lm[7]);
    lumal = lsum[25:2];
    hprod = hi * 32'(edge_ratio);
    ratio_thr = hprod[31:8];
    t_thr = max24({edge_floor, 8'd0}, ratio_thr);
    rdiff = (q > {1'b0, subpixel_trim, 8'd0}) ? q - {1'b0, subpixel_trim, 8'd0} : 17'd0;
    bt3   = 27'(bt) + {1'b0, bt, 1'b0};
    fprod = 33'(q) * 33'(blendl);
    mprod = 40'(sums[ch]) * 40'(RECIP9);
    cprod = 26'(contrast) * 26'(subpixel_cap);
    cf    = (cprod > 26'h10000) ? 17'h10000 : cprod[16:0];
    mix_sum = acc + 33'(mean[ch]) * 33'(blend) + 33'h8000;
    s_diff = absdiff(slum, lm[4]);
    hit    = ({2'b0, s_diff, 2'b0} >= grad4);
    rs     = (dcnt == '0) ? dr : {dr[23:0], 1'b0};
    rs_ge  = (rs >= {1'b0, dden});
  end

  // memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_of(AW'(req.column), AW'(req.row));
    mem_wdata = pixel_t'({req.red_in, req.green_in, req.blue_in});
    mem_re    = 1'b0;
    mem_raddr = addr_of(AW'(req.column), AW'(req.row));
    priority case (1'b1)
      (state == S_IDLE): begin
        mem_we = take && (command_t'(req.command) == CMD_WRITE) && req_inside;
        mem_re = take && (command_t'(req.command) == CMD_READ) && req_inside;
      end
      (state == S_WB): begin
        mem_we    = 1'b1;
        mem_waddr = addr_of(AW'(x), AW'(y));
        mem_wdata = pixel_t'({newc[0], newc[1], newc[2]});
      end
      (state == S_LOAD): begin
        mem_re    = (lidx < 4'd9);
        mem_raddr = addr_of(AW'(x) + AW'(wj) - AW'(1), AW'(y) + AW'(wi) - AW'(1));
      end
      (state == S_SRCH): begin
        mem_re    = !dir_end;
        mem_raddr = addr_of(AW'(nx), AW'(ny));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata <= mem[mem_raddr];
  end

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      // states that load a response handle their own valid
      if (rsp_valid && rsp_ready && state != S_RD && state != S_DONE) rsp_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (take) begin
            unique case (command_t'(req.command))
              CMD_READ: begin
                rd_inside <= req_inside;
                state     <= S_RD;
              end
              CMD_FILTER: begin
                wlim <= wsat;
                hlim <= hsat;
                x    <= XW'(1);
                y    <= YW'(1);
                lidx <= '0;
                wi   <= '0;
                wj   <= '0;
                state <= (wsat < XW'(3) || hsat < YW'(3)) ? S_DONE : S_LOAD;
              end
              default: ;
            endcase
          end
        end

        S_RD: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid <= 1'b1;
            rsp.red_out     <= rd_inside ? rdata.red   : 16'd0;
            rsp.green_out   <= rd_inside ? rdata.green : 16'd0;
            rsp.blue_out    <= rd_inside ? rdata.blue  : 16'd0;
            rsp.filter_done <= 1'b0;
            state <= S_IDLE;
          end
        end

        S_DONE: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid <= 1'b1;
            rsp.red_out     <= 16'd0;
            rsp.green_out   <= 16'd0;
            rsp.blue_out    <= 16'd0;
            rsp.filter_done <= 1'b1;
            state <= S_IDLE;
          end
        end

        // read issue at lidx, data for lidx-1 arrives
        S_LOAD: begin
          if (lidx == '0) begin
            sums[0] <= '0;
            sums[1] <= '0;
            sums[2] <= '0;
          end else begin
            lm[lidx - 4'd1] <= luma(rdata);
            sums[0] <= sums[0] + 20'(rdata.red);
            sums[1] <= sums[1] + 20'(rdata.green);
            sums[2] <= sums[2] + 20'(rdata.blue);
            if (lidx == 4'd5) begin
              mch[0] <= rdata.red;
              mch[1] <= rdata.green;
              mch[2] <= rdata.blue;
            end
          end
          if (wj == 2'd2) begin
            wj <= '0;
            wi <= wi + 2'd1;
          end else begin
            wj <= wj + 2'd1;
          end
          lidx  <= lidx + 4'd1;
          if (lidx == 4'd9) state <= S_RANGE;
        end

        S_RANGE: begin
          hi    <= t_hi;
          lo    <= t_lo;
          rng   <= t_hi - t_lo;
          diffl <= absdiff(lumal, lm[4]);
          ev <= 28'(lap(lm[0], lm[1], lm[2])) + {1'b0, lap(lm[3], lm[4], lm[5]), 1'b0}
              + 28'(lap(lm[6], lm[7], lm[8]));
          eh <= 28'(lap(lm[0], lm[3], lm[6])) + {1'b0, lap(lm[1], lm[4], lm[7]), 1'b0}
              + 28'(lap(lm[2], lm[5], lm[8]));
          state <= S_THR;
        end

        S_THR: begin
          if (rng < t_thr) begin
            state <= S_NEXT;
          end else if (rng == '0) begin
            q     <= '0;
            state <= S_BLEND1;
          end else begin
            dr     <= {1'b0, diffl};
            dden   <= rng;
            q      <= '0;
            dcnt   <= '0;
            div_fb <= 1'b0;
            state  <= S_DIV;
          end
        end

        // restoring division, 17 quotient bits, numerator <= denominator
        S_DIV: begin
          dr   <= rs_ge ? rs - {1'b0, dden} : rs;
          q    <= {q[15:0], rs_ge};
          dcnt <= dcnt + 5'd1;
          if (dcnt == 5'd16) state <= div_fb ? S_FBB : S_BLEND1;
        end

        S_BLEND1: begin
          bt    <= 25'(rdiff) * 25'(subpixel_cap);
          state <= S_BLEND2;
        end

        S_BLEND2: begin
          blendl <= (bt3[26:9] > {2'b0, subpixel_cap, 8'd0}) ? {subpixel_cap, 8'd0}
                                                              : bt3[24:9];
          state  <= S_SSET;
        end

        S_SSET: begin
          horz   <= (eh >= ev);
          grad4  <= (eh >= ev) ? eh : ev;
          sx     <= x;
          sy     <= y;
          dir    <= 1'b0;
          tries  <= '0;
          dist_n <= '0;
          dist_p <= '0;
          state  <= S_SRCH;
        end

        S_SRCH: begin
          if (dir_end) begin
            if (!dir) begin
              dir   <= 1'b1;
              sx    <= x;
              sy    <= y;
              tries <= '0;
            end else begin
              state <= S_FBSET;
            end
          end else begin
            state <= S_SWAIT;
          end
        end

        S_SWAIT: begin
          slum  <= luma(rdata);
          state <= S_SCMP;
        end

        S_SCMP: begin
          if (hit) begin
            if (!dir) begin
              dir   <= 1'b1;
              sx    <= x;
              sy    <= y;
              tries <= '0;
              state <= S_SRCH;
            end else begin
              state <= S_FBSET;
            end
          end else begin
            sx    <= nx;
            sy    <= ny;
            tries <= tries + SW'(1);
            if (dir) dist_p <= dist_p + SW'(1);
            else     dist_n <= dist_n + SW'(1);
            state <= S_SRCH;
          end
        end

        S_FBSET: begin
          if (dist_n == '0 && dist_p == '0) begin
            q     <= 17'h10000;
            state <= S_FBB;
          end else begin
            dr     <= 25'(dist_n);
            dden   <= 24'(dist_n) + 24'(dist_p);
            q      <= '0;
            dcnt   <= '0;
            div_fb <= 1'b1;
            state  <= S_DIV;
          end
        end

        S_FBB: begin
          fbb   <= fprod[32:16];
          ch    <= '0;
          state <= S_MEAN;
        end

        S_MEAN: begin
          mean[ch] <= mprod[38:23];
          ch <= ch + 2'd1;
          if (ch == 2'd2) state <= S_CONTR;
        end

        S_CONTR: begin
          contrast <= 18'(absdiff(24'(mch[0]), 24'(mean[0])))
                    + 18'(absdiff(24'(mch[1]), 24'(mean[1])))
                    + 18'(absdiff(24'(mch[2]), 24'(mean[2])));
          state <= S_CF;
        end

        S_CF: begin
          blend <= (fbb > cf) ? fbb : cf;
          ch    <= '0;
          phase <= 1'b0;
          state <= S_MIX;
        end

        S_MIX: begin
          if (!phase) begin
            acc   <= 33'(mch[ch]) * (33'h10000 - 33'(blend));
            phase <= 1'b1;
          end else begin
            newc[ch] <= mix_sum[31:16];
            phase    <= 1'b0;
            ch       <= ch + 2'd1;
            if (ch == 2'd2) state <= S_WB;
          end
        end

        S_WB: state <= S_NEXT;

        S_NEXT: begin
          lidx <= '0;
          wi   <= '0;
          wj   <= '0;
          if ((XW'(x) + XW'(2)) < wlim) begin
            x     <= x + XW'(1);
            state <= S_LOAD;
          end else begin
            x <= XW'(1);
            if ((YW'(y) + YW'(2)) < hlim) begin
              y     <= y + YW'(1);
              state <= S_LOAD;
            end else begin
              state <= S_DONE;
            end
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
